>>> rtl/mlp_pkg.sv
// Shared constants, layout helpers and pipeline control type for the perceptron block.
package mlp_pkg;

  localparam int DATA_WIDTH     = 16;
  localparam int INPUT_COUNT    = 4;
  localparam int FIRST_HIDDEN   = 8;
  localparam int SECOND_HIDDEN  = 6;
  localparam int OUTPUT_COUNT   = 1;
  localparam int STORE_DEPTH    = 128;
  localparam int FRAC_BITS      = 12;
  localparam int INDEX_W        = 7;
  localparam int CFG_W          = 32;
  localparam int CFG_IDX_W      = 1;
  localparam int OUT_W          = 32;

  // store layout, row-major, each layer's weights then its biases
  localparam int L0_W = 0;
  localparam int L0_B = L0_W + INPUT_COUNT * FIRST_HIDDEN;
  localparam int L1_W = L0_B + FIRST_HIDDEN;
  localparam int L1_B = L1_W + FIRST_HIDDEN * SECOND_HIDDEN;
  localparam int L2_W = L1_B + SECOND_HIDDEN;
  localparam int L2_B = L2_W + SECOND_HIDDEN * OUTPUT_COUNT;

  // activation memory layout: features, first hidden, second hidden
  localparam int A0_BASE   = 0;
  localparam int A1_BASE   = A0_BASE + INPUT_COUNT;
  localparam int A2_BASE   = A1_BASE + FIRST_HIDDEN;
  localparam int ACT_DEPTH = A2_BASE + SECOND_HIDDEN;

  localparam int WADDR_W = $clog2(STORE_DEPTH);
  localparam int AADDR_W = (ACT_DEPTH > 1) ? $clog2(ACT_DEPTH) : 1;
  localparam int FSEL_W  = (INPUT_COUNT > 1) ? $clog2(INPUT_COUNT) : 1;

  localparam int MAX_FAN0 = (INPUT_COUNT > FIRST_HIDDEN) ? INPUT_COUNT : FIRST_HIDDEN;
  localparam int MAX_FAN  = (MAX_FAN0 > SECOND_HIDDEN) ? MAX_FAN0 : SECOND_HIDDEN;
  localparam int MAX_CNT  = (FIRST_HIDDEN > SECOND_HIDDEN) ? FIRST_HIDDEN : SECOND_HIDDEN;
  localparam int KCNT_W   = $clog2(MAX_FAN + 1);
  localparam int NCNT_W   = $clog2(MAX_CNT + 1);

  localparam int OPB_W  = CFG_W + 1;
  localparam int PROD_W = DATA_WIDTH + OPB_W;

  localparam int     ONE_Q    = 1 << FRAC_BITS;
  localparam int     HALF_Q   = 1 << (FRAC_BITS - 1);
  localparam longint DATA_MAX = (longint'(1) <<< (DATA_WIDTH - 1)) - 1;
  localparam longint DATA_MIN = -DATA_MAX - 1;
  localparam longint OUT_MAX  = (longint'(1) <<< (OUT_W - 1)) - 1;
  localparam longint OUT_MIN  = -OUT_MAX - 1;

  localparam logic [CFG_W-1:0]     SCALE_RESET  = 32'd65536;
  localparam logic [CFG_W-1:0]     OFFSET_RESET = 32'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SCALE    = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_OFFSET   = 1'b1;
  localparam logic                 FUNC_WRITE   = 1'b0;
  localparam logic                 FUNC_INFER   = 1'b1;

  typedef enum logic [1:0] {LYR_H1, LYR_H2, LYR_OUT} layer_t;

  typedef struct packed {
    logic               vld;
    logic               bias;
    logic               last;
    logic               hidden;
    logic               scale;
    logic [AADDR_W-1:0] waddr;
  } mac_ctl_t;

  function automatic logic [KCNT_W-1:0] fan_in(layer_t l);
    logic [KCNT_W-1:0] r;
    unique case (l)
      LYR_H1:  r = KCNT_W'(INPUT_COUNT);
      LYR_H2:  r = KCNT_W'(FIRST_HIDDEN);
      LYR_OUT: r = KCNT_W'(SECOND_HIDDEN);
      default: r = KCNT_W'(SECOND_HIDDEN);
    endcase
    return r;
  endfunction

  function automatic logic [NCNT_W-1:0] last_neuron(layer_t l);
    logic [NCNT_W-1:0] r;
    unique case (l)
      LYR_H1:  r = NCNT_W'(FIRST_HIDDEN - 1);
      LYR_H2:  r = NCNT_W'(SECOND_HIDDEN - 1);
      LYR_OUT: r = NCNT_W'(OUTPUT_COUNT - 1);
      default: r = NCNT_W'(OUTPUT_COUNT - 1);
    endcase
    return r;
  endfunction

  function automatic logic [WADDR_W-1:0] w_base(layer_t l);
    logic [WADDR_W-1:0] r;
    unique case (l)
      LYR_H1:  r = WADDR_W'(L0_W);
      LYR_H2:  r = WADDR_W'(L1_W);
      LYR_OUT: r = WADDR_W'(L2_W);
      default: r = WADDR_W'(L2_W);
    endcase
    return r;
  endfunction

  function automatic logic [WADDR_W-1:0] b_base(layer_t l);
    logic [WADDR_W-1:0] r;
    unique case (l)
      LYR_H1:  r = WADDR_W'(L0_B);
      LYR_H2:  r = WADDR_W'(L1_B);
      LYR_OUT: r = WADDR_W'(L2_B);
      default: r = WADDR_W'(L2_B);
    endcase
    return r;
  endfunction

  function automatic logic [AADDR_W-1:0] in_base(layer_t l);
    logic [AADDR_W-1:0] r;
    unique case (l)
      LYR_H1:  r = AADDR_W'(A0_BASE);
      LYR_H2:  r = AADDR_W'(A1_BASE);
      LYR_OUT: r = AADDR_W'(A2_BASE);
      default: r = AADDR_W'(A2_BASE);
    endcase
    return r;
  endfunction

  // output neuron is not stored; its base is unused
  function automatic logic [AADDR_W-1:0] out_base(layer_t l);
    logic [AADDR_W-1:0] r;
    unique case (l)
      LYR_H1:  r = AADDR_W'(A1_BASE);
      LYR_H2:  r = AADDR_W'(A2_BASE);
      LYR_OUT: r = AADDR_W'(A0_BASE);
      default: r = AADDR_W'(A0_BASE);
    endcase
    return r;
  endfunction

endpackage

>>> rtl/mlp_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
module mlp_ram #(
  parameter int DEPTH = 128,
  parameter int WIDTH = 16,
  parameter int AW    = 7
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> rtl/mlp_seq.sv
// Sequencer: feature load, per-neuron address generation, layer drains and final scaling.
module mlp_seq import mlp_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic               in_func,
  input  logic               pipe_busy,
  input  logic               fin,
  output logic               busy,
  output logic               clr,
  output logic               ld_we,
  output logic [AADDR_W-1:0] ld_addr,
  output mac_ctl_t           ctl,
  output logic [WADDR_W-1:0] w_raddr,
  output logic [AADDR_W-1:0] a_raddr
);

  typedef enum logic [2:0] {ST_IDLE, ST_LOAD, ST_ISSUE, ST_DRAIN, ST_SCALE, ST_FINISH} state_t;

  state_t             state_r, state_nxt;
  layer_t             layer_r, layer_nxt, layer_up;
  logic [KCNT_W-1:0]  k_r, k_nxt;
  logic [NCNT_W-1:0]  n_r, n_nxt;
  logic [WADDR_W-1:0] wptr_r, wptr_nxt, bptr_r, bptr_nxt;
  logic [AADDR_W-1:0] aptr_r, aptr_nxt;
  logic [FSEL_W-1:0]  lcnt_r, lcnt_nxt;

  assign busy     = (state_r != ST_IDLE);
  assign clr      = (state_r == ST_LOAD);
  assign ld_we    = (state_r == ST_LOAD);
  assign ld_addr  = AADDR_W'(A0_BASE) + AADDR_W'(lcnt_r);
  assign layer_up = (layer_r == LYR_H1) ? LYR_H2 : LYR_OUT;

  always_comb begin
    state_nxt = state_r;
    layer_nxt = layer_r;
    k_nxt     = k_r;
    n_nxt     = n_r;
    wptr_nxt  = wptr_r;
    bptr_nxt  = bptr_r;
    aptr_nxt  = aptr_r;
    lcnt_nxt  = lcnt_r;
    ctl       = '0;
    w_raddr   = wptr_r;
    a_raddr   = aptr_r;
    unique case (state_r)
      ST_IDLE: begin
        if (start && in_func == FUNC_INFER) begin
          state_nxt = ST_LOAD;
          lcnt_nxt  = '0;
        end
      end
      ST_LOAD: begin
        lcnt_nxt = lcnt_r + FSEL_W'(1);
        if (lcnt_r == FSEL_W'(INPUT_COUNT - 1)) begin
          state_nxt = ST_ISSUE;
          layer_nxt = LYR_H1;
          wptr_nxt  = w_base(LYR_H1);
          bptr_nxt  = b_base(LYR_H1);
          k_nxt     = '0;
          n_nxt     = '0;
        end
      end
      ST_ISSUE: begin
        ctl.vld    = 1'b1;
        ctl.bias   = (k_r == '0);
        ctl.last   = (k_r == fan_in(layer_r));
        ctl.hidden = (layer_r != LYR_OUT);
        ctl.waddr  = out_base(layer_r) + AADDR_W'(n_r);
        if (k_r == '0) begin
          w_raddr  = bptr_r;
          bptr_nxt = bptr_r + WADDR_W'(1);
          aptr_nxt = in_base(layer_r);
          k_nxt    = KCNT_W'(1);
        end else begin
          wptr_nxt = wptr_r + WADDR_W'(1);
          aptr_nxt = aptr_r + AADDR_W'(1);
          if (k_r == fan_in(layer_r)) begin
            k_nxt = '0;
            if (n_r == last_neuron(layer_r)) begin
              state_nxt = ST_DRAIN;
            end else begin
              n_nxt = n_r + NCNT_W'(1);
            end
          end else begin
            k_nxt = k_r + KCNT_W'(1);
          end
        end
      end
      ST_DRAIN: begin
        // wait for the last activation write of the layer
        if (!pipe_busy) begin
          if (layer_r == LYR_OUT) begin
            state_nxt = ST_SCALE;
          end else begin
            state_nxt = ST_ISSUE;
            layer_nxt = layer_up;
            wptr_nxt  = w_base(layer_up);
            bptr_nxt  = b_base(layer_up);
            k_nxt     = '0;
            n_nxt     = '0;
          end
        end
      end
      ST_SCALE: begin
        ctl.vld   = 1'b1;
        ctl.bias  = 1'b1;
        ctl.last  = 1'b1;
        ctl.scale = 1'b1;
        state_nxt = ST_FINISH;
      end
      ST_FINISH: begin
        if (fin) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      layer_r <= LYR_H1;
      k_r     <= '0;
      n_r     <= '0;
      lcnt_r  <= '0;
    end else begin
      state_r <= state_nxt;
      layer_r <= layer_nxt;
      k_r     <= k_nxt;
      n_r     <= n_nxt;
      lcnt_r  <= lcnt_nxt;
    end
    wptr_r <= wptr_nxt;
    bptr_r <= bptr_nxt;
    aptr_r <= aptr_nxt;
  end

endmodule

>>> rtl/mlp_mac.sv
// Shared multiply-accumulate pipeline with rounding, clipping, ReLU and output denormalization.
module mlp_mac import mlp_pkg::*; (
  input  logic                        clk,
  input  logic                        rst_n,
  input  mac_ctl_t                    ctl,
  input  logic                        clr,
  input  logic signed [DATA_WIDTH-1:0] w_rdata,
  input  logic signed [DATA_WIDTH-1:0] a_rdata,
  input  logic        [CFG_W-1:0]      scale,
  input  logic signed [CFG_W-1:0]      offset,
  output logic                        pipe_busy,
  output logic                        fin,
  output logic                        act_we,
  output logic        [AADDR_W-1:0]    act_waddr,
  output logic        [DATA_WIDTH-1:0] act_wdata,
  output logic                        res_vld,
  output logic signed [OUT_W-1:0]      res_pred,
  output logic                        res_sat
);

  mac_ctl_t s1_r, s2_r, s3_r;

  logic signed [DATA_WIDTH-1:0] op_a, y_r;
  logic signed [OPB_W-1:0]      op_b;
  logic signed [PROD_W-1:0]     prod_r, acc_r, base, acc_nxt, rnd, hi, lo, clp;
  logic                         clip_hit, done3, sat_r;

  // stage 1: multiply
  always_comb begin
    op_a = s1_r.scale ? y_r : w_rdata;
    priority if (s1_r.scale) begin
      op_b = $signed({1'b0, scale});
    end else if (s1_r.bias) begin
      op_b = OPB_W'(ONE_Q);
    end else begin
      op_b = OPB_W'(a_rdata);
    end
  end

  // stage 2: accumulate; offset folded in before rounding
  always_comb begin
    if (s2_r.bias) begin
      base = s2_r.scale ? (PROD_W'(offset) <<< FRAC_BITS) : '0;
    end else begin
      base = acc_r;
    end
    acc_nxt = base + prod_r;
  end

  // stage 3: round half up, clip
  always_comb begin
    rnd      = (acc_r + PROD_W'(HALF_Q)) >>> FRAC_BITS;
    hi       = s3_r.scale ? PROD_W'(OUT_MAX) : PROD_W'(DATA_MAX);
    lo       = s3_r.scale ? PROD_W'(OUT_MIN) : PROD_W'(DATA_MIN);
    clip_hit = 1'b0;
    priority if (rnd > hi) begin
      clp      = hi;
      clip_hit = 1'b1;
    end else if (rnd < lo) begin
      clp      = lo;
      clip_hit = 1'b1;
    end else begin
      clp = rnd;
    end
  end

  assign done3     = s3_r.vld && s3_r.last;
  assign pipe_busy = s1_r.vld || s2_r.vld || s3_r.vld;
  assign fin       = done3 && s3_r.scale;
  assign act_we    = done3 && s3_r.hidden;
  assign act_waddr = s3_r.waddr;
  assign act_wdata = clp[DATA_WIDTH-1] ? '0 : clp[DATA_WIDTH-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_r    <= '0;
      s2_r    <= '0;
      s3_r    <= '0;
      sat_r   <= 1'b0;
      res_vld <= 1'b0;
    end else begin
      s1_r    <= ctl;
      s2_r    <= s1_r;
      s3_r    <= s2_r;
      res_vld <= fin;
      if (clr) begin
        sat_r <= 1'b0;
      end else if (done3 && clip_hit) begin
        sat_r <= 1'b1;
      end
    end
    prod_r <= op_a * op_b;
    if (s2_r.vld) begin
      acc_r <= acc_nxt;
    end
    if (done3 && !s3_r.hidden && !s3_r.scale) begin
      y_r <= clp[DATA_WIDTH-1:0];
    end
    if (fin) begin
      res_pred <= clp[OUT_W-1:0];
      res_sat  <= sat_r || clip_hit;
    end
  end

endmodule

>>> rtl/mlp_relu_inference.sv
// Top level: 4-8-6-1 ReLU perceptron, weight store write and inference on one shared multiplier.
// Write transaction: taken while idle, no result, busy stays low.
// Infer transaction: a feature load, then the single multiplier doing one weight read and
// multiply-accumulate per cycle (101 in all) with a pipeline drain after each layer, then
// the scaling pass and the out_valid strobe. A new transaction is accepted in the cycle of
// the strobe. Synchronous reset clears control; the weight store is undefined until
// written; scale resets to 16.0 (12 fraction bits) and offset to 0.
module mlp_relu_inference import mlp_pkg::*; (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  output logic                        busy,
  input  logic                        in_func,
  input  logic        [INDEX_W-1:0]    in_store_index,
  input  logic signed [DATA_WIDTH-1:0] in_store_value,
  input  logic signed [DATA_WIDTH-1:0] in_feature_0,
  input  logic signed [DATA_WIDTH-1:0] in_feature_1,
  input  logic signed [DATA_WIDTH-1:0] in_feature_2,
  input  logic signed [DATA_WIDTH-1:0] in_feature_3,
  output logic                        out_valid,
  output logic signed [OUT_W-1:0]      out_prediction,
  output logic                        out_saturated,
  input  logic                        cfg_we,
  input  logic        [CFG_IDX_W-1:0]  cfg_index,
  input  logic        [CFG_W-1:0]      cfg_data
);

  logic        [CFG_W-1:0]      scale_r;
  logic signed [CFG_W-1:0]      offset_r;
  logic signed [DATA_WIDTH-1:0] feat_r [INPUT_COUNT];

  logic               accept, w_we, clr, ld_we, pipe_busy, fin;
  logic               act_we, mac_we;
  logic [AADDR_W-1:0] ld_addr, a_raddr, act_waddr, mac_waddr;
  logic [WADDR_W-1:0] w_raddr;
  logic [DATA_WIDTH-1:0] w_rdata, a_rdata, act_wdata, mac_wdata;
  mac_ctl_t           ctl;

  assign accept = start && !busy;
  assign w_we   = accept && (in_func == FUNC_WRITE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scale_r  <= SCALE_RESET;
      offset_r <= OFFSET_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_SCALE:  scale_r  <= cfg_data;
        CFG_OFFSET: offset_r <= cfg_data;
      endcase
    end
    if (accept && in_func == FUNC_INFER) begin
      feat_r[0] <= in_feature_0;
      feat_r[1] <= in_feature_1;
      feat_r[2] <= in_feature_2;
      feat_r[3] <= in_feature_3;
    end
  end

  assign act_we    = ld_we || mac_we;
  assign act_waddr = ld_we ? ld_addr : mac_waddr;
  assign act_wdata = ld_we ? feat_r[ld_addr[FSEL_W-1:0]] : mac_wdata;

  mlp_ram #(.DEPTH(STORE_DEPTH), .WIDTH(DATA_WIDTH), .AW(WADDR_W)) u_wmem (
    .clk   (clk),
    .we    (w_we),
    .waddr (WADDR_W'(in_store_index)),
    .wdata (in_store_value),
    .raddr (w_raddr),
    .rdata (w_rdata)
  );

  mlp_ram #(.DEPTH(ACT_DEPTH), .WIDTH(DATA_WIDTH), .AW(AADDR_W)) u_amem (
    .clk   (clk),
    .we    (act_we),
    .waddr (act_waddr),
    .wdata (act_wdata),
    .raddr (a_raddr),
    .rdata (a_rdata)
  );

  mlp_seq u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .in_func   (in_func),
    .pipe_busy (pipe_busy),
    .fin       (fin),
    .busy      (busy),
    .clr       (clr),
    .ld_we     (ld_we),
    .ld_addr   (ld_addr),
    .ctl       (ctl),
    .w_raddr   (w_raddr),
    .a_raddr   (a_raddr)
  );

  mlp_mac u_mac (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (ctl),
    .clr       (clr),
    .w_rdata   (w_rdata),
    .a_rdata   (a_rdata),
    .scale     (scale_r),
    .offset    (offset_r),
    .pipe_busy (pipe_busy),
    .fin       (fin),
    .act_we    (mac_we),
    .act_waddr (mac_waddr),
    .act_wdata (mac_wdata),
    .res_vld   (out_valid),
    .res_pred  (out_prediction),
    .res_sat   (out_saturated)
  );

endmodule

>>> rtl/mlp_chk.sv
// Port-level checker for the perceptron top level, attached by bind.
module mlp_chk import mlp_pkg::*; (
  input logic clk,
  input logic rst_n,
  input logic start,
  input logic busy,
  input logic in_func,
  input logic out_valid
);

  // infer transaction makes the block busy
  a_infer_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && in_func == FUNC_INFER |=> busy)
    else $error("infer transaction did not raise busy");

  // write transaction completes at once with no result
  a_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && in_func == FUNC_WRITE |=> !busy && !out_valid)
    else $error("write transaction disturbed busy or produced a result");

  // a result only closes a busy period
  a_res_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(busy))
    else $error("result strobe without a preceding busy cycle");

  a_busy_ends_res: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(busy) |-> out_valid)
    else $error("busy dropped without a result");

  a_single_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe held longer than one cycle");

endmodule

bind mlp_relu_inference mlp_chk u_mlp_chk (.*);

>>> tb/sv/tb_top.sv
// Self-checking testbench for the mlp_relu_inference perceptron block.
module tb_top;
  import mlp_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 3000000;
  localparam int ITEM_TARGET = 1450;
  localparam int IDLE_HOLD   = 8;
  localparam int SETTLE      = 130;

  typedef enum logic [1:0] {ITEM_XACT, ITEM_CFG, ITEM_DRAIN} item_kind_t;
  typedef enum int {VAL_FULL, VAL_SMALL, VAL_EDGE} val_style_t;

  typedef struct packed {
    item_kind_t                            kind;
    logic                                  func;
    logic [INDEX_W-1:0]                    index;
    logic [DATA_WIDTH-1:0]                 value;
    logic [INPUT_COUNT-1:0][DATA_WIDTH-1:0] feat;
    logic [CFG_IDX_W-1:0]                  reg_index;
    logic [CFG_W-1:0]                      reg_data;
  } item_t;

  typedef struct packed {
    logic signed [OUT_W-1:0] prediction;
    logic                    saturated;
  } prediction_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic in_func = FUNC_WRITE;
  logic [INDEX_W-1:0] in_store_index = '0;
  logic signed [DATA_WIDTH-1:0] in_store_value = '0;
  logic signed [DATA_WIDTH-1:0] in_feature_0 = '0;
  logic signed [DATA_WIDTH-1:0] in_feature_1 = '0;
  logic signed [DATA_WIDTH-1:0] in_feature_2 = '0;
  logic signed [DATA_WIDTH-1:0] in_feature_3 = '0;
  logic out_valid;
  logic signed [OUT_W-1:0] out_prediction;
  logic out_saturated;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = CFG_SCALE;
  logic [CFG_W-1:0] cfg_data = '0;

  // mirror of the block's state
  logic signed [DATA_WIDTH-1:0] weight_mirror [STORE_DEPTH];
  logic [CFG_W-1:0] scale_mirror = SCALE_RESET;
  logic signed [CFG_W-1:0] offset_mirror = OFFSET_RESET;

  item_t stim_q [$];
  prediction_t pending_predictions [$];
  item_t cur;
  int xact_count = 0;
  int errors = 0;
  int cycles = 0;
  int idle_cycles = 0;
  int burst_left = 8;
  int gap_left = 0;

  always #6 clk = ~clk;

  mlp_relu_inference dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .in_func       (in_func),
    .in_store_index(in_store_index),
    .in_store_value(in_store_value),
    .in_feature_0  (in_feature_0),
    .in_feature_1  (in_feature_1),
    .in_feature_2  (in_feature_2),
    .in_feature_3  (in_feature_3),
    .out_valid     (out_valid),
    .out_prediction(out_prediction),
    .out_saturated (out_saturated),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  // round half up to Q.12, clip to the data range
  function automatic longint requant(input longint acc, inout bit sat);
    longint q;
    q = (acc + HALF_Q) >>> FRAC_BITS;
    if (q > DATA_MAX) begin
      sat = 1'b1;
      q = DATA_MAX;
    end else if (q < DATA_MIN) begin
      sat = 1'b1;
      q = DATA_MIN;
    end
    return q;
  endfunction

  function automatic prediction_t model_infer(
      input logic [INPUT_COUNT-1:0][DATA_WIDTH-1:0] feat);
    longint x [INPUT_COUNT];
    longint h1 [FIRST_HIDDEN];
    longint h2 [SECOND_HIDDEN];
    longint acc, y, p;
    bit sat;
    prediction_t r;
    sat = 1'b0;
    for (int i = 0; i < INPUT_COUNT; i++) x[i] = longint'($signed(feat[i]));
    for (int n = 0; n < FIRST_HIDDEN; n++) begin
      acc = longint'(weight_mirror[L0_B + n]) * ONE_Q;
      for (int k = 0; k < INPUT_COUNT; k++)
        acc += longint'(weight_mirror[L0_W + n * INPUT_COUNT + k]) * x[k];
      h1[n] = requant(acc, sat);
      if (h1[n] < 0) h1[n] = 0;
    end
    for (int n = 0; n < SECOND_HIDDEN; n++) begin
      acc = longint'(weight_mirror[L1_B + n]) * ONE_Q;
      for (int k = 0; k < FIRST_HIDDEN; k++)
        acc += longint'(weight_mirror[L1_W + n * FIRST_HIDDEN + k]) * h1[k];
      h2[n] = requant(acc, sat);
      if (h2[n] < 0) h2[n] = 0;
    end
    acc = longint'(weight_mirror[L2_B]) * ONE_Q;
    for (int k = 0; k < SECOND_HIDDEN; k++)
      acc += longint'(weight_mirror[L2_W + k]) * h2[k];
    y = requant(acc, sat);
    p = ((y * longint'(scale_mirror)) + HALF_Q) >>> FRAC_BITS;
    p += longint'(offset_mirror);
    if (p > OUT_MAX) begin
      sat = 1'b1;
      p = OUT_MAX;
    end else if (p < OUT_MIN) begin
      sat = 1'b1;
      p = OUT_MIN;
    end
    r.prediction = p[OUT_W-1:0];
    r.saturated = sat;
    return r;
  endfunction

  function automatic logic [DATA_WIDTH-1:0] pick_value(input val_style_t s);
    logic [DATA_WIDTH-1:0] v;
    case (s)
      VAL_SMALL: v = DATA_WIDTH'($urandom_range(0, 4096) - 2048);
      VAL_EDGE: begin
        case ($urandom_range(0, 4))
          0: v = 16'h8000;
          1: v = 16'h7FFF;
          2: v = 16'h0000;
          3: v = 16'hFFFF;
          default: v = 16'h0001;
        endcase
      end
      default: v = DATA_WIDTH'($urandom);
    endcase
    return v;
  endfunction

  function automatic val_style_t random_style();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 60) return VAL_SMALL;
    if (roll < 85) return VAL_FULL;
    return VAL_EDGE;
  endfunction

  function automatic logic [INPUT_COUNT-1:0][DATA_WIDTH-1:0] random_features();
    logic [INPUT_COUNT-1:0][DATA_WIDTH-1:0] f;
    for (int i = 0; i < INPUT_COUNT; i++) f[i] = pick_value(random_style());
    return f;
  endfunction

  function automatic void push_store(input int idx, input logic [DATA_WIDTH-1:0] val);
    item_t it;
    it = '0;
    it.kind = ITEM_XACT;
    it.func = FUNC_WRITE;
    it.index = INDEX_W'(idx);
    it.value = val;
    it.feat = {$urandom, $urandom};
    stim_q.push_back(it);
    xact_count++;
  endfunction

  function automatic void push_infer(input logic [INPUT_COUNT-1:0][DATA_WIDTH-1:0] f);
    item_t it;
    it = '0;
    it.kind = ITEM_XACT;
    it.func = FUNC_INFER;
    it.index = INDEX_W'($urandom);
    it.value = DATA_WIDTH'($urandom);
    it.feat = f;
    stim_q.push_back(it);
    xact_count++;
  endfunction

  function automatic void push_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
    item_t it;
    it = '0;
    it.kind = ITEM_CFG;
    it.reg_index = idx;
    it.reg_data = data;
    stim_q.push_back(it);
  endfunction

  function automatic void push_drain();
    item_t it;
    it = '0;
    it.kind = ITEM_DRAIN;
    stim_q.push_back(it);
  endfunction

  function automatic void load_range(input int lo, input int hi, input bit mostly_small);
    for (int a = lo; a <= hi; a++)
      push_store(a, pick_value((mostly_small && $urandom_range(0, 9) < 8) ?
                               VAL_SMALL : random_style()));
  endfunction

  function automatic logic [CFG_W-1:0] pick_scale();
    case ($urandom_range(0, 5))
      0: return SCALE_RESET;
      1: return 32'h0000_0000;
      2: return 32'hFFFF_FFFF;
      3: return 32'($urandom);
      default: return 32'($urandom_range(0, 32'h0004_0000));
    endcase
  endfunction

  function automatic logic [CFG_W-1:0] pick_offset();
    case ($urandom_range(0, 4))
      0: return OFFSET_RESET;
      1: return 32'h8000_0000;
      2: return 32'h7FFF_FFFF;
      3: return 32'($urandom);
      default: return 32'($urandom_range(0, 32'h0010_0000)) - 32'h0008_0000;
    endcase
  endfunction

  always @(posedge clk) begin : driver
    item_t head;
    logic start_nx;
    logic we_nx;
    start_nx = start;
    we_nx = 1'b0;
    if (!rst_n) begin
      start_nx = 1'b0;
      idle_cycles = 0;
    end else begin
      if (start || busy || pending_predictions.size() != 0) idle_cycles = 0;
      else idle_cycles++;
      if (start && !busy) begin
        if (cur.func == FUNC_WRITE) weight_mirror[cur.index] = cur.value;
        else pending_predictions.push_back(model_infer(cur.feat));
        start_nx = 1'b0;
      end
      if (!start_nx) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (stim_q.size() > 0) begin
          head = stim_q[0];
          case (head.kind)
            ITEM_XACT: begin
              head = stim_q.pop_front();
              cur = head;
              in_func <= head.func;
              in_store_index <= head.index;
              in_store_value <= head.value;
              in_feature_0 <= head.feat[0];
              in_feature_1 <= head.feat[1];
              in_feature_2 <= head.feat[2];
              in_feature_3 <= head.feat[3];
              start_nx = 1'b1;
              burst_left--;
              if (burst_left <= 0) begin
                burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(30, 80)
                                                         : $urandom_range(1, 20);
                gap_left = ($urandom_range(0, 3) == 0) ? $urandom_range(100, 140)
                                                       : $urandom_range(1, 12);
              end
            end
            ITEM_CFG: begin
              if (idle_cycles >= IDLE_HOLD) begin
                head = stim_q.pop_front();
                we_nx = 1'b1;
                cfg_index <= head.reg_index;
                cfg_data <= head.reg_data;
                if (head.reg_index == CFG_SCALE) scale_mirror = head.reg_data;
                else offset_mirror = head.reg_data;
                idle_cycles = 0;
              end
            end
            default: begin
              if (idle_cycles >= IDLE_HOLD) head = stim_q.pop_front();
            end
          endcase
        end
      end
    end
    start <= start_nx;
    cfg_we <= we_nx;
  end

  always @(posedge clk) begin : monitor
    prediction_t want;
    if (rst_n && out_valid) begin
      if (pending_predictions.size() == 0) begin
        $error("unexpected result: prediction %0d saturated %0b", out_prediction, out_saturated);
        errors++;
      end else begin
        want = pending_predictions.pop_front();
        if (out_prediction !== want.prediction) begin
          $error("prediction mismatch: expected %0d, actual %0d", want.prediction, out_prediction);
          errors++;
        end
        if (out_saturated !== want.saturated) begin
          $error("saturated mismatch: expected %0b, actual %0b", want.saturated, out_saturated);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin : watchdog
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin : stimulus
    int roll;
    int sel;
    int next_phase;
    logic [INPUT_COUNT-1:0][DATA_WIDTH-1:0] f;

    // directed: config, load of every weight and bias, extremes
    push_reg(CFG_SCALE, 32'h0002_0000);
    push_reg(CFG_OFFSET, 32'h0001_0000);
    load_range(L0_W, L2_B, 1'b1);
    push_infer('0);
    push_infer({4{16'h7FFF}});
    push_infer({4{16'h8000}});
    push_infer({16'hFFFF, 16'h0001, 16'h8000, 16'h7FFF});
    push_store(STORE_DEPTH - 1, 16'h8000);
    push_store(L2_B + 1, 16'h7FFF);
    // first hidden neuron clips
    push_store(L0_B, 16'h7FFF);
    push_store(L0_W, 16'h7FFF);
    push_infer({4{16'h7FFF}});
    push_store(L0_B, pick_value(VAL_SMALL));
    push_store(L0_W, pick_value(VAL_SMALL));
    // output bias at minimum
    push_store(L2_B, 16'h8000);
    push_infer(random_features());
    push_store(L2_B, pick_value(VAL_SMALL));
    push_drain();
    push_reg(CFG_SCALE, 32'h0000_0000);
    push_infer(random_features());
    push_reg(CFG_SCALE, 32'hFFFF_FFFF);
    push_infer({4{16'h7FFF}});
    push_reg(CFG_OFFSET, 32'h7FFF_FFFF);
    push_infer(random_features());
    push_reg(CFG_OFFSET, 32'h8000_0000);
    push_infer(random_features());
    push_reg(CFG_SCALE, SCALE_RESET);
    push_reg(CFG_OFFSET, OFFSET_RESET);

    // random traffic
    next_phase = xact_count + 200;
    while (xact_count < ITEM_TARGET) begin
      if (xact_count >= next_phase) begin
        push_reg(CFG_SCALE, pick_scale());
        push_reg(CFG_OFFSET, pick_offset());
        next_phase = xact_count + 200;
      end
      roll = $urandom_range(0, 99);
      if (roll < 50) begin
        push_infer(random_features());
      end else if (roll < 85) begin
        push_store($urandom_range(0, STORE_DEPTH - 1), pick_value(random_style()));
      end else if (roll < 95) begin
        sel = $urandom_range(0, 2);
        if (sel == 0) load_range(L0_W, L1_W - 1, 1'b1);
        else if (sel == 1) load_range(L1_W, L2_W - 1, 1'b1);
        else load_range(L2_W, L2_B, 1'b1);
        repeat ($urandom_range(1, 4)) begin
          f = random_features();
          push_infer(f);
        end
      end else begin
        push_drain();
      end
    end

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    while (stim_q.size() != 0 || start || pending_predictions.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);

    if (errors == 0 && pending_predictions.size() == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end

endmodule

>>> files.f
rtl/mlp_pkg.sv
rtl/mlp_ram.sv
rtl/mlp_seq.sv
rtl/mlp_mac.sv
rtl/mlp_relu_inference.sv
rtl/mlp_chk.sv
tb/sv/tb_top.sv
